/* design/assert_macros.svh */
// Assertion helpers for the design files; the encoder unit includes them.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MHL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MHL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/mhl_pkg.sv */
// ----------------------------------------------------------------------------
// Maidenhead locator encoder package
// Widths, grid limits, per-level divisor/reciprocal tables and the item type.
// ----------------------------------------------------------------------------
package mhl_pkg;

   localparam int LOCATOR_PAIRS = 5;
   localparam int LEVELS        = 5;

   localparam int COORD_W     = 32;
   localparam int REM_W       = 28;  // largest divisor is 2e8 < 2^28
   localparam int VAL_W       = 37;  // remainder times scale
   localparam int QUOT_W      = 5;   // digit never exceeds 23
   localparam int RECIP_W     = 14;
   localparam int SCALE_W     = 5;
   localparam int CHAR_W      = 7;
   localparam int RECIP_SHIFT = 32;
   localparam int PROD_W      = COORD_W + RECIP_W;

   localparam logic signed [COORD_W-1:0] LAT_MIN = -32'sd900000000;
   localparam logic signed [COORD_W-1:0] LAT_MAX = 32'sd899999999;
   localparam logic signed [COORD_W-1:0] LON_MIN = -32'sd1800000000;
   localparam logic signed [COORD_W-1:0] LON_MAX = 32'sd1799999999;

   localparam logic [COORD_W-1:0] LAT_OFFSET = 32'd900000000;
   localparam logic [COORD_W-1:0] LON_OFFSET = 32'd1800000000;

   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_R = 7'h52;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 7'h39;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;

   typedef enum logic [2:0] {
      LEVEL_FIELD       = 3'd0,
      LEVEL_SQUARE      = 3'd1,
      LEVEL_SUBSQUARE   = 3'd2,
      LEVEL_EXTENDED    = 3'd3,
      LEVEL_SUBEXTENDED = 3'd4
   } level_type;

   localparam logic [REM_W-1:0] LON_DIV [LEVELS] = '{
      28'd200000000, 28'd20000000, 28'd10000000, 28'd10000000, 28'd10000000};
   localparam logic [REM_W-1:0] LAT_DIV [LEVELS] = '{
      28'd100000000, 28'd10000000, 28'd10000000, 28'd10000000, 28'd10000000};

   localparam logic [SCALE_W-1:0] LON_SCALE [LEVELS] = '{5'd1, 5'd1, 5'd12, 5'd10, 5'd24};
   localparam logic [SCALE_W-1:0] LAT_SCALE [LEVELS] = '{5'd1, 5'd1, 5'd24, 5'd10, 5'd24};

   // floor(scale * 2^32 / divisor): estimate is never high and at most one low
   localparam logic [RECIP_W-1:0] LON_RECIP [LEVELS] = '{
      14'((64'd1  << 32) / 64'd200000000),
      14'((64'd1  << 32) / 64'd20000000),
      14'((64'd12 << 32) / 64'd10000000),
      14'((64'd10 << 32) / 64'd10000000),
      14'((64'd24 << 32) / 64'd10000000)};
   localparam logic [RECIP_W-1:0] LAT_RECIP [LEVELS] = '{
      14'((64'd1  << 32) / 64'd100000000),
      14'((64'd1  << 32) / 64'd10000000),
      14'((64'd24 << 32) / 64'd10000000),
      14'((64'd10 << 32) / 64'd10000000),
      14'((64'd24 << 32) / 64'd10000000)};

   localparam logic [CHAR_W-1:0] CHAR_BASE [LEVELS] = '{
      CHAR_UPPER_A, CHAR_DIGIT_0, CHAR_LOWER_A, CHAR_DIGIT_0, CHAR_LOWER_A};

   typedef struct packed {
      logic                           valid;
      logic                           located;
      logic [COORD_W-1:0]             lon_rem;
      logic [COORD_W-1:0]             lat_rem;
      logic [LEVELS-1:0][CHAR_W-1:0]  lon_char;
      logic [LEVELS-1:0][CHAR_W-1:0]  lat_char;
   } item_type;

endpackage

/* design/mhl_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Coordinate pair with presence flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mhl_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] latitude_e7;
   logic [31:0] longitude_e7;
   logic        latitude_present;
   logic        longitude_present;

   modport source (output valid, output latitude_e7, output longitude_e7,
                   output latitude_present, output longitude_present, input ready);
   modport sink   (input valid, input latitude_e7, input longitude_e7,
                   input latitude_present, input longitude_present, output ready);
endinterface

/* design/mhl_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Ten locator characters plus a valid flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mhl_rsp_if;
   logic       valid;
   logic       ready;
   logic       locator_valid;
   logic [6:0] field_lon_char;
   logic [6:0] field_lat_char;
   logic [5:0] square_lon_char;
   logic [5:0] square_lat_char;
   logic [6:0] subsquare_lon_char;
   logic [6:0] subsquare_lat_char;
   logic [5:0] extended_lon_char;
   logic [5:0] extended_lat_char;
   logic [6:0] subextended_lon_char;
   logic [6:0] subextended_lat_char;

   modport source (output valid, output locator_valid,
                   output field_lon_char, output field_lat_char,
                   output square_lon_char, output square_lat_char,
                   output subsquare_lon_char, output subsquare_lat_char,
                   output extended_lon_char, output extended_lat_char,
                   output subextended_lon_char, output subextended_lat_char,
                   input ready);
   modport sink   (input valid, input locator_valid,
                   input field_lon_char, input field_lat_char,
                   input square_lon_char, input square_lat_char,
                   input subsquare_lon_char, input subsquare_lat_char,
                   input extended_lon_char, input extended_lat_char,
                   input subextended_lon_char, input subextended_lat_char,
                   output ready);
endinterface

/* design/maidenhead_locator_encoder_unit.sv */
// ----------------------------------------------------------------------------
// Maidenhead locator encoder unit
// Coordinate pair in, ten-character grid locator out, fully pipelined.
// ----------------------------------------------------------------------------
//  Channel   Dir   Modport  Carries
//  req_port  in    sink     latitude_e7, longitude_e7, presence flags
//  rsp_port  out   source   locator_valid and ten ASCII locator characters
//
// One transaction enters per cycle while rsp_port is not stalled. There is one clamp stage,
// then two register stages per character pair (reciprocal estimate, then
// remainder and one-step correction), five pairs deep.
// Reset clears only the valid bits of every stage; payload is left as is.
// A stall on rsp_port freezes the whole pipeline in place; req_port.ready
// drops only while the output holds a transaction that is not taken.
`include "assert_macros.svh"

module maidenhead_locator_encoder_unit
   import mhl_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   mhl_req_if.sink   req_port,
   mhl_rsp_if.source rsp_port
);

   item_type chain [LEVELS+1];
   item_type out_item;
   logic     advance;

   // qualifiers for the output checks
   logic     out_blank;
   logic     out_shown;
   logic     blank_ok;
   logic     lon_field_ok;
   logic     lat_field_ok;
   logic     square_ok;

   // advance everything whenever the output slot is empty or being drained
   assign advance       = !out_item.valid || rsp_port.ready;
   assign req_port.ready = advance;

   mhl_front u_front (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .in_valid          (req_port.valid),
      .latitude_e7       (req_port.latitude_e7),
      .longitude_e7      (req_port.longitude_e7),
      .latitude_present  (req_port.latitude_present),
      .longitude_present (req_port.longitude_present),
      .out_item          (chain[0])
   );

   // one level per character pair, field first
   for (genvar i = 0; i < LEVELS; i++) begin : g_level
      mhl_level u_level (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .level    (level_type'(i)),
         .in_item  (chain[i]),
         .out_item (chain[i+1])
      );
   end

   assign out_item = chain[LEVELS];

   // drive the response straight from the last level register
   assign rsp_port.valid                = out_item.valid;
   assign rsp_port.locator_valid        = out_item.located;
   assign rsp_port.field_lon_char       = out_item.lon_char[LEVEL_FIELD];
   assign rsp_port.field_lat_char       = out_item.lat_char[LEVEL_FIELD];
   assign rsp_port.square_lon_char      = out_item.lon_char[LEVEL_SQUARE][5:0];
   assign rsp_port.square_lat_char      = out_item.lat_char[LEVEL_SQUARE][5:0];
   assign rsp_port.subsquare_lon_char   = out_item.lon_char[LEVEL_SUBSQUARE];
   assign rsp_port.subsquare_lat_char   = out_item.lat_char[LEVEL_SUBSQUARE];
   assign rsp_port.extended_lon_char    = out_item.lon_char[LEVEL_EXTENDED][5:0];
   assign rsp_port.extended_lat_char    = out_item.lat_char[LEVEL_EXTENDED][5:0];
   assign rsp_port.subextended_lon_char = out_item.lon_char[LEVEL_SUBEXTENDED];
   assign rsp_port.subextended_lat_char = out_item.lat_char[LEVEL_SUBEXTENDED];

   assign out_blank    = out_item.valid && !out_item.located;
   assign out_shown    = out_item.valid && out_item.located;
   assign blank_ok     = (out_item.lon_char == '0) && (out_item.lat_char == '0);
   assign lon_field_ok = (out_item.lon_char[LEVEL_FIELD] >= CHAR_UPPER_A) &&
                         (out_item.lon_char[LEVEL_FIELD] <= CHAR_UPPER_R);
   assign lat_field_ok = (out_item.lat_char[LEVEL_FIELD] >= CHAR_UPPER_A) &&
                         (out_item.lat_char[LEVEL_FIELD] <= CHAR_UPPER_R);
   assign square_ok    = (LOCATOR_PAIRS <= 1) ||
                         ((out_item.lon_char[LEVEL_SQUARE] >= CHAR_DIGIT_0) &&
                          (out_item.lon_char[LEVEL_SQUARE] <= CHAR_DIGIT_9) &&
                          (out_item.lat_char[LEVEL_SQUARE] >= CHAR_DIGIT_0) &&
                          (out_item.lat_char[LEVEL_SQUARE] <= CHAR_DIGIT_9));

   // a missing coordinate must leave every character blank
   `MHL_ASSERT_IMP(a_blank_when_absent, clock, reset, out_blank, blank_ok, "blank chars expected")

   // clamped longitude field stays within A..R
   `MHL_ASSERT_IMP(a_lon_field_range, clock, reset, out_shown, lon_field_ok, "bad lon field")

   // clamped latitude field stays within A..R
   `MHL_ASSERT_IMP(a_lat_field_range, clock, reset, out_shown, lat_field_ok, "bad lat field")

   // a wrong reciprocal correction shows up as a square digit past 9
   `MHL_ASSERT_IMP(a_square_digit_range, clock, reset, out_shown, square_ok, "bad square digit")

endmodule

/* design/mhl_front.sv */
// ----------------------------------------------------------------------------
// Locator front stage
// Clamp both coordinates to the grid and shift them to unsigned offsets.
// ----------------------------------------------------------------------------
module mhl_front
   import mhl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic [COORD_W-1:0] latitude_e7,
   input  logic [COORD_W-1:0] longitude_e7,
   input  logic               latitude_present,
   input  logic               longitude_present,
   output item_type           out_item
);

   logic signed [COORD_W-1:0] lat_s;
   logic signed [COORD_W-1:0] lon_s;
   logic signed [COORD_W-1:0] lat_c;
   logic signed [COORD_W-1:0] lon_c;
   item_type                  front_in;
   item_type                  front_ff;

   always_comb begin
      lat_s = $signed(latitude_e7);
      lon_s = $signed(longitude_e7);
      lat_c = (lat_s < LAT_MIN) ? LAT_MIN : ((lat_s > LAT_MAX) ? LAT_MAX : lat_s);
      lon_c = (lon_s < LON_MIN) ? LON_MIN : ((lon_s > LON_MAX) ? LON_MAX : lon_s);

      front_in          = '0;
      front_in.valid    = in_valid;
      front_in.located  = latitude_present & longitude_present;
      // wraps mod 2^32 into the nonnegative offset
      front_in.lat_rem  = $unsigned(lat_c) + LAT_OFFSET;
      front_in.lon_rem  = $unsigned(lon_c) + LON_OFFSET;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else if (advance) begin
         front_ff <= front_in;
      end
   end

   assign out_item = front_ff;

endmodule

/* design/mhl_level.sv */
// ----------------------------------------------------------------------------
// Locator character level
// One character pair: reciprocal estimate, then remainder and correction.
// ----------------------------------------------------------------------------
module mhl_level
   import mhl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  level_type level,
   input  item_type  in_item,
   output item_type  out_item
);

   typedef struct packed {
      item_type            item;
      logic [QUOT_W-1:0]   lon_q;
      logic [QUOT_W-1:0]   lat_q;
      logic [VAL_W-1:0]    lon_v;
      logic [VAL_W-1:0]    lat_v;
   } est_type;

   logic [PROD_W-1:0] lon_prod;
   logic [PROD_W-1:0] lat_prod;
   est_type           stage_a_in;
   est_type           stage_a_ff;

   logic [VAL_W-1:0]  lon_t;
   logic [VAL_W-1:0]  lat_t;
   logic [VAL_W-1:0]  lon_div;
   logic [VAL_W-1:0]  lat_div;
   logic              lon_fix;
   logic              lat_fix;
   logic [REM_W-1:0]  lon_rem;
   logic [REM_W-1:0]  lat_rem;
   logic [QUOT_W-1:0] lon_quot;
   logic [QUOT_W-1:0] lat_quot;
   logic              keep;
   item_type          stage_b_in;
   item_type          stage_b_ff;

   // estimate digit from the reciprocal, scale the remainder alongside
   always_comb begin
      lon_prod         = PROD_W'(in_item.lon_rem) * PROD_W'(LON_RECIP[level]);
      lat_prod         = PROD_W'(in_item.lat_rem) * PROD_W'(LAT_RECIP[level]);
      stage_a_in.item  = in_item;
      stage_a_in.lon_q = lon_prod[RECIP_SHIFT +: QUOT_W];
      stage_a_in.lat_q = lat_prod[RECIP_SHIFT +: QUOT_W];
      stage_a_in.lon_v = VAL_W'(in_item.lon_rem) * VAL_W'(LON_SCALE[level]);
      stage_a_in.lat_v = VAL_W'(in_item.lat_rem) * VAL_W'(LAT_SCALE[level]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_a_ff.item.valid <= 1'b0;
      end else if (advance) begin
         stage_a_ff <= stage_a_in;
      end
   end

   // remainder is in [0, 2*div): one conditional subtract settles the digit
   always_comb begin
      lon_div  = VAL_W'(LON_DIV[level]);
      lat_div  = VAL_W'(LAT_DIV[level]);
      lon_t    = stage_a_ff.lon_v - VAL_W'(stage_a_ff.lon_q) * lon_div;
      lat_t    = stage_a_ff.lat_v - VAL_W'(stage_a_ff.lat_q) * lat_div;
      lon_fix  = (lon_t >= lon_div);
      lat_fix  = (lat_t >= lat_div);
      lon_rem  = REM_W'(lon_fix ? (lon_t - lon_div) : lon_t);
      lat_rem  = REM_W'(lat_fix ? (lat_t - lat_div) : lat_t);
      lon_quot = stage_a_ff.lon_q + QUOT_W'(lon_fix);
      lat_quot = stage_a_ff.lat_q + QUOT_W'(lat_fix);
      keep     = stage_a_ff.item.located && (int'(level) < LOCATOR_PAIRS);

      stage_b_in         = stage_a_ff.item;
      stage_b_in.lon_rem = COORD_W'(lon_rem);
      stage_b_in.lat_rem = COORD_W'(lat_rem);
      stage_b_in.lon_char[level] = keep ? (CHAR_BASE[level] + CHAR_W'(lon_quot)) : '0;
      stage_b_in.lat_char[level] = keep ? (CHAR_BASE[level] + CHAR_W'(lat_quot)) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_b_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_b_ff <= stage_b_in;
      end
   end

   assign out_item = stage_b_ff;

endmodule
